// ===== hdl/ofr_pkg.sv =====
// ofr_pkg: shared types, constants and matcher function for the optical frame receiver
// no dependencies; imported by every ofr module
`default_nettype none

package ofr_pkg;

  localparam int SampleWidth    = 10;
  localparam int SpeedWidth     = 7;
  localparam int FieldWidth     = 9;
  localparam int CountWidth     = 8;
  localparam int StageWidth     = 2;
  localparam int FieldIdxWidth  = 4;

  localparam logic [SampleWidth-1:0] ThresholdReset = 10'd410;
  localparam logic [3:0] HeaderPattern  = 4'b1011;
  localparam logic [3:0] TrailerPattern = 4'b1010;
  localparam logic [CountWidth-1:0] StoredBits = 8'd9;
  localparam logic [CountWidth-1:0] CountMax   = 8'd255;
  localparam logic [StageWidth-1:0] LastStage  = 2'd3;

  typedef struct packed {
    logic [SpeedWidth-1:0] speed;
    logic                  brake;
    logic                  lane;
    logic [CountWidth-1:0] payload_length;
  } ofr_result_t;

  typedef struct packed {
    logic [StageWidth-1:0] stage;
    logic                  done;
  } ofr_match_t;

  // one step of the four-stage pattern matcher, first pattern bit in bit 3
  function automatic ofr_match_t match_step(input logic [3:0] pattern,
                                            input logic [StageWidth-1:0] stage,
                                            input logic bit_in);
    ofr_match_t m;
    logic expected;
    expected = pattern[LastStage - stage];
    m.done  = 1'b0;
    m.stage = '0;
    if (bit_in == expected) begin
      if (stage == LastStage) begin
        m.done = 1'b1;
      end else begin
        m.stage = stage + 2'd1;
      end
    end else begin
      m.stage = {1'b0, bit_in};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ofr_in_stage.sv =====
// ofr_in_stage: input register holding one sample request for the deframer
// depends on ofr_pkg
`default_nettype none

module ofr_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ofr_pkg::SampleWidth-1:0] sample,
  output logic                                 held_valid,
  output logic [ofr_pkg::SampleWidth-1:0]      held_sample,
  input  wire logic                            advance
);
  import ofr_pkg::*;

  // room when empty or when the held request moves on this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_sample <= sample;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ofr_deframer.sv =====
// ofr_deframer: bit slicer, header/trailer matcher and payload capture
// depends on ofr_pkg
`default_nettype none

module ofr_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [ofr_pkg::SampleWidth-1:0] threshold,
  input  wire logic                            advance,
  input  wire logic [ofr_pkg::SampleWidth-1:0] held_sample,
  output logic                                 res_valid,
  output ofr_pkg::ofr_result_t                 res
);
  import ofr_pkg::*;

  logic                  in_frame, in_frame_next;
  logic [StageWidth-1:0] match_stage, match_stage_next;
  logic [FieldWidth-1:0] field_bits, field_bits_next;
  logic [CountWidth-1:0] bit_count, bit_count_next;

  logic                  bit_in;
  ofr_match_t            m;
  logic [FieldWidth-1:0] field_upd;
  logic [CountWidth-1:0] count_upd;

  assign bit_in = (held_sample >= threshold);

  always_comb begin
    in_frame_next    = in_frame;
    match_stage_next = match_stage;
    field_bits_next  = field_bits;
    bit_count_next   = bit_count;
    res_valid        = 1'b0;
    field_upd        = field_bits;
    count_upd        = bit_count;
    m = match_step(in_frame ? TrailerPattern : HeaderPattern, match_stage, bit_in);

    if (bit_count < StoredBits) begin
      field_upd[bit_count[FieldIdxWidth-1:0]] = bit_in;
    end
    if (bit_count < CountMax) begin
      count_upd = bit_count + 8'd1;
    end

    for (int k = 0; k < SpeedWidth; k++) begin
      res.speed[SpeedWidth-1-k] = field_upd[k];
    end
    res.brake          = field_upd[7];
    res.lane           = field_upd[8];
    res.payload_length = count_upd;

    match_stage_next = m.stage;
    if (!in_frame) begin
      if (m.done) begin
        in_frame_next   = 1'b1;
        field_bits_next = '0;
        bit_count_next  = '0;
      end
    end else if (m.done) begin
      res_valid       = 1'b1;
      in_frame_next   = 1'b0;
      field_bits_next = '0;
      bit_count_next  = '0;
    end else begin
      field_bits_next = field_upd;
      bit_count_next  = count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      match_stage <= '0;
      field_bits  <= '0;
      bit_count   <= '0;
    end else if (advance) begin
      in_frame    <= in_frame_next;
      match_stage <= match_stage_next;
      field_bits  <= field_bits_next;
      bit_count   <= bit_count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_frame)
    else $error("result raised while hunting header");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> (!in_frame && bit_count == '0 && match_stage == '0))
    else $error("frame state not cleared after result");

  a_hunt_idle: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (bit_count == '0 && field_bits == '0))
    else $error("payload state dirty while hunting");

  a_min_length: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.payload_length >= 8'd4)
    else $error("frame shorter than trailer");
`endif

endmodule

`default_nettype wire

// ===== hdl/ofr_out_stage.sv =====
// ofr_out_stage: result register presenting one frame result to the consumer
// depends on ofr_pkg
`default_nettype none

module ofr_out_stage (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           held_valid,
  input  wire logic                           res_valid,
  input  wire ofr_pkg::ofr_result_t           res,
  output logic                                advance,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ofr_pkg::SpeedWidth-1:0]      speed,
  output logic                                brake,
  output logic                                lane,
  output logic [ofr_pkg::CountWidth-1:0]      payload_length
);
  import ofr_pkg::*;

  ofr_result_t res_q;
  logic        room;

  // a held request moves on whenever the result register can take a new value
  assign room    = !out_valid || out_ready;
  assign advance = held_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign speed          = res_q.speed;
  assign brake          = res_q.brake;
  assign lane           = res_q.lane;
  assign payload_length = res_q.payload_length;

endmodule

`default_nettype wire

// ===== hdl/optical_frame_receiver.sv =====
// optical_frame_receiver: top level of the sync-word and trailer deframer
// depends on ofr_pkg, ofr_in_stage, ofr_deframer, ofr_out_stage
//
// usage:
//   sample channel (in_valid/in_ready/sample): one 10-bit sensor reading per
//   bit period; a request is taken on a clock edge with valid and ready high.
//   result channel (out_valid/out_ready/speed/brake/lane/payload_length):
//   one request per frame, raised on the sample that completes trailer 1010.
//   bit_threshold_we/bit_threshold_wdata write the slicing threshold; write
//   it only while no sample is in flight.
// path: an accepted sample sits in the input register, and any result it
//   completes is registered in the result register; throughput is one sample
//   per cycle while the result register can take a value, the matcher update
//   being combinational between the two registers.
// reset (rst, synchronous): hunting for header 1011, threshold 410, both
//   registers empty.
// stall: while a result waits on out_ready the held sample waits too, and
//   in_ready drops once the input register is full; nothing is dropped.
`default_nettype none

module optical_frame_receiver (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            bit_threshold_we,
  input  wire logic [ofr_pkg::SampleWidth-1:0] bit_threshold_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ofr_pkg::SampleWidth-1:0] sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ofr_pkg::SpeedWidth-1:0]       speed,
  output logic                                 brake,
  output logic                                 lane,
  output logic [ofr_pkg::CountWidth-1:0]       payload_length
);
  import ofr_pkg::*;

  logic [SampleWidth-1:0] bit_threshold;
  logic                   held_valid;
  logic [SampleWidth-1:0] held_sample;
  logic                   advance;
  logic                   res_valid;
  ofr_result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold <= ThresholdReset;
    end else if (bit_threshold_we) begin
      bit_threshold <= bit_threshold_wdata;
    end
  end

  ofr_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .held_valid  (held_valid),
    .held_sample (held_sample),
    .advance     (advance)
  );

  ofr_deframer u_deframer (
    .clk         (clk),
    .rst         (rst),
    .threshold   (bit_threshold),
    .advance     (advance),
    .held_sample (held_sample),
    .res_valid   (res_valid),
    .res         (res)
  );

  ofr_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .held_valid     (held_valid),
    .res_valid      (res_valid),
    .res            (res),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .speed          (speed),
    .brake          (brake),
    .lane           (lane),
    .payload_length (payload_length)
  );

endmodule

`default_nettype wire

// ===== tb/tb_optical_frame_receiver.sv =====
// tb_optical_frame_receiver: self-checking bench for the optical frame receiver
// depends on ofr_pkg and optical_frame_receiver; predicts frames from the sliced bit stream
// and checks every result request against them in order

module tb_optical_frame_receiver;
  import ofr_pkg::*;

  // predicts deframer results from accepted samples and checks the block's output
  class frame_scoreboard;
    logic [SampleWidth-1:0] threshold;
    logic                   in_frame;
    logic [StageWidth-1:0]  stage;
    logic [FieldWidth-1:0]  field_bits;
    logic [CountWidth-1:0]  bit_count;
    ofr_result_t            expected_frames[$];
    int                     errors;

    function new();
      threshold  = ThresholdReset;
      in_frame   = 1'b0;
      stage      = '0;
      field_bits = '0;
      bit_count  = '0;
      errors     = 0;
    endfunction

    function int pending_frames();
      return expected_frames.size();
    endfunction

    // shared four-stage matcher, first pattern bit in bit 3
    function bit advance(input logic [3:0] pattern, input logic b);
      logic want;
      want = pattern[3 - stage];
      if (b == want) begin
        if (stage == 2'd3) begin
          stage = '0;
          return 1'b1;
        end
        stage = stage + 2'd1;
        return 1'b0;
      end
      stage = {1'b0, b};
      return 1'b0;
    endfunction

    function void note_sample(input logic [SampleWidth-1:0] value);
      logic        b;
      ofr_result_t frame;
      int          k;
      b = (value >= threshold);
      if (!in_frame) begin
        if (advance(HeaderPattern, b)) begin
          in_frame   = 1'b1;
          field_bits = '0;
          bit_count  = '0;
        end
        return;
      end
      if (bit_count < StoredBits) field_bits[bit_count[FieldIdxWidth-1:0]] = b;
      if (bit_count != CountMax) bit_count = bit_count + 8'd1;
      if (!advance(TrailerPattern, b)) return;
      // payload bit 0 lands in the speed msb
      for (k = 0; k < SpeedWidth; k++) frame.speed[SpeedWidth-1-k] = field_bits[k];
      frame.brake          = field_bits[7];
      frame.lane           = field_bits[8];
      frame.payload_length = bit_count;
      expected_frames.push_back(frame);
      in_frame   = 1'b0;
      stage      = '0;
      field_bits = '0;
      bit_count  = '0;
    endfunction

    function void compare_field(input string what, input int want, input int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_frame(input ofr_result_t got);
      ofr_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, got speed %0d brake %0d lane %0d length %0d",
                 $time, got.speed, got.brake, got.lane, got.payload_length);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("speed", want.speed, got.speed);
      compare_field("brake", want.brake, got.brake);
      compare_field("lane", want.lane, got.lane);
      compare_field("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   bit_threshold_we = 1'b0;
  logic [SampleWidth-1:0] bit_threshold_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SampleWidth-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SpeedWidth-1:0]  speed;
  logic                   brake;
  logic                   lane;
  logic [CountWidth-1:0]  payload_length;

  frame_scoreboard sb;
  int send_idle_pct = 8;
  int recv_idle_pct = 63;
  int items_sent = 0;
  int quiet_cycles = 0;

  optical_frame_receiver u_top (
    .clk                 (clk),
    .rst                 (rst),
    .bit_threshold_we    (bit_threshold_we),
    .bit_threshold_wdata (bit_threshold_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .sample              (sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .speed               (speed),
    .brake               (brake),
    .lane                (lane),
    .payload_length      (payload_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        sb.note_sample(sample);
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        sb.check_frame(ofr_result_t'{speed, brake, lane, payload_length});
        quiet_cycles = 0;
      end
      if (quiet_cycles >= 3000) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
        $display("tb_optical_frame_receiver: done, errors");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [SampleWidth-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // random sample on the requested side of thr, sometimes at the edge; any if b=0, thr=0
  function automatic logic [SampleWidth-1:0] sample_for(input logic b, input int thr);
    if (!b && thr == 0) return SampleWidth'($urandom_range(1023, 0));
    if ($urandom_range(7) == 0) return b ? SampleWidth'(thr) : SampleWidth'(thr - 1);
    if (b) return SampleWidth'($urandom_range(1023, thr));
    return SampleWidth'($urandom_range(thr - 1, 0));
  endfunction

  task automatic send_bit(input logic b);
    send_sample(sample_for(b, sb.threshold));
  endtask

  task automatic send_pattern(input logic [3:0] pattern);
    int i;
    for (i = 3; i >= 0; i--) send_bit(pattern[i]);
  endtask

  // header, len payload bits, trailer; a clean payload never holds the trailer itself
  task automatic send_frame(input int len, input bit clean_payload);
    logic [2:0] tail;
    logic       b;
    int         i;
    tail = 3'b000;
    send_pattern(HeaderPattern);
    for (i = 0; i < len; i++) begin
      b = 1'($urandom_range(1));
      if (clean_payload && tail == 3'b101 && !b) b = 1'b1;
      send_bit(b);
      tail = {tail[1:0], b};
    end
    send_pattern(TrailerPattern);
  endtask

  task automatic random_traffic(input int count);
    int start_count;
    int pick;
    int len;
    start_count = items_sent;
    while (items_sent - start_count < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // two zeros bring the header matcher back to its first stage
        if ($urandom_range(4) != 0) begin
          send_bit(1'b0);
          send_bit(1'b0);
        end
        len = $urandom_range(99);
        if (len < 70) len = $urandom_range(12, 0);
        else if (len < 95) len = $urandom_range(40, 13);
        else len = $urandom_range(120, 41);
        send_frame(len, 1'($urandom_range(1)));
      end else if (pick < 85) begin
        repeat ($urandom_range(8, 1)) send_sample(SampleWidth'($urandom_range(1023)));
      end else begin
        // header followed by a few loose bits, trailer left out
        send_pattern(HeaderPattern);
        repeat ($urandom_range(6, 1)) send_bit(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic write_threshold(input logic [SampleWidth-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending_frames() != 0) @(posedge clk);
    // a sample that ends no frame may still sit in the pipeline
    repeat (4) @(posedge clk);
    bit_threshold_we    <= 1'b1;
    bit_threshold_wdata <= value;
    sb.threshold = value;
    @(posedge clk);
    bit_threshold_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest frame, samples at the extremes and on both sides of the threshold
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(ThresholdReset);
    send_sample(10'd1023);
    send_sample(ThresholdReset);
    send_sample(ThresholdReset - 10'd1);
    send_sample(10'd1023);
    send_sample(10'd0);
    // all nine stored bits present, brake and lane set
    send_pattern(HeaderPattern);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_bit(1'b1);
    send_pattern(TrailerPattern);

    write_threshold(10'd1023);
    random_traffic(60);
    write_threshold(10'd0);
    random_traffic(20);
    write_threshold(SampleWidth'($urandom_range(1022, 1)));
    random_traffic(380);

    send_idle_pct = 63;
    recv_idle_pct = 8;
    write_threshold(ThresholdReset);
    random_traffic(380);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(SampleWidth'($urandom_range(900, 100)));
    // long frame, length saturates
    send_bit(1'b0);
    send_bit(1'b0);
    send_frame(280, 1'b1);
    random_traffic(240);

    in_valid <= 1'b0;
    while (sb.pending_frames() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_frames() != 0) begin
      $display("%0t: %0d frames never arrived", $time, sb.pending_frames());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_optical_frame_receiver: done, clean");
    end else begin
      $display("tb_optical_frame_receiver: done, errors");
    end
    $finish;
  end

endmodule
